[hdl/button_debounce_hold_classifier_core_defines.svh]
// Assertion macros shared by the checker of the button debounce core.
// No dependencies; included by name where assertions are written.
`ifndef BUTTON_DEBOUNCE_HOLD_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_HOLD_CLASSIFIER_CORE_DEFINES_SVH

// Clocked property, switched off while reset is asserted
`define BDHC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked property that is also checked during reset
`define BDHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[hdl/bdhc_pkg.sv]
// Shared types and constants of the button debounce and hold classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bdhc_pkg;

    // Default timer width and width of the configuration registers
    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int LEVEL_OUT_W     = 16;

    // A hold threshold of this value disables its step
    localparam logic [CFG_W-1:0] NO_HOLD = '0;

    // Register reset values
    localparam logic [CFG_W-1:0] PRESS_DB_RST   = 16'd1;
    localparam logic [CFG_W-1:0] RELEASE_DB_RST = 16'd2;
    localparam logic [CFG_W-1:0] HOLD_RST       = 16'd0;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_DB   = 3'd0,
        CFG_RELEASE_DB = 3'd1,
        CFG_HOLD_START = 3'd2,
        CFG_HOLD_SHORT = 3'd3,
        CFG_HOLD_LONG  = 3'd4
    } t_cfg_idx;

    // Reported button states
    typedef enum logic [2:0] {
        ST_RELEASED   = 3'd0,
        ST_PRESSED    = 3'd1,
        ST_HOLD_START = 3'd2,
        ST_HOLD_SHORT = 3'd3,
        ST_HOLD_LONG  = 3'd4
    } t_btn_state;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0] press_db;
        logic [CFG_W-1:0] release_db;
        logic [CFG_W-1:0] hold_start;
        logic [CFG_W-1:0] hold_short;
        logic [CFG_W-1:0] hold_long;
    } t_cfg;

    // One result item
    typedef struct packed {
        t_btn_state             button_state;
        t_btn_state             previous_state;
        logic                   state_changed;
        logic                   is_idle;
        logic [LEVEL_OUT_W-1:0] level_ticks;
    } t_result;

endpackage

[hdl/button_debounce_hold_classifier_core.sv]
// Button debouncer with hold-time classification.
// The tick is held in the input register, then its result in the result register.
// Throughput: one tick per cycle unless stalled; the state update is combinational.
// The input register can take one tick while a result waits to be taken.
// Reset is synchronous, active low: clears the valid flags and the button
// state and timers, and loads the register reset values.
`timescale 1ns / 1ps

module button_debounce_hold_classifier_core
    import bdhc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tick input channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_raw_active,
    input  logic                   i_press_edge,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_button_state,
    output logic [2:0]             o_previous_state,
    output logic                   o_state_changed,
    output logic                   o_is_idle,
    output logic [LEVEL_OUT_W-1:0] o_level_ticks,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    t_cfg    cfg;
    t_result step_result;
    logic    advance;
    logic    in_take;

    logic    r_in_vld;
    logic    r_in_raw;
    logic    r_in_edge;
    logic    r_out_vld;
    t_result r_out;

    bdhc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bdhc_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_raw_active (r_in_raw),
        .i_press_edge (r_in_edge),
        .i_cfg        (cfg),
        .o_result     (step_result)
    );

    // Handshake: the held item moves on when the result register has room
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_take    = i_in_valid && o_in_ready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_raw  <= i_raw_active;
            r_in_edge <= i_press_edge;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_button_state   = r_out.button_state;
    assign o_previous_state = r_out.previous_state;
    assign o_state_changed  = r_out.state_changed;
    assign o_is_idle        = r_out.is_idle;
    assign o_level_ticks    = r_out.level_ticks;

endmodule

[hdl/bdhc_cfg_regs.sv]
// Configuration register file of the button debounce core.
// Depends on bdhc_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps

module bdhc_cfg_regs
    import bdhc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_db   <= PRESS_DB_RST;
            r_cfg.release_db <= RELEASE_DB_RST;
            r_cfg.hold_start <= HOLD_RST;
            r_cfg.hold_short <= HOLD_RST;
            r_cfg.hold_long  <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PRESS_DB:   r_cfg.press_db   <= i_cfg_wdata;
                CFG_RELEASE_DB: r_cfg.release_db <= i_cfg_wdata;
                CFG_HOLD_START: r_cfg.hold_start <= i_cfg_wdata;
                CFG_HOLD_SHORT: r_cfg.hold_short <= i_cfg_wdata;
                CFG_HOLD_LONG:  r_cfg.hold_long  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/bdhc_step.sv]
// Per-tick datapath: debounce and level timers, debounced level and state.
// Depends on bdhc_pkg for the state encoding, config and result structs.
`timescale 1ns / 1ps

module bdhc_step
    import bdhc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_raw_active,
    input  logic    i_press_edge,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    // Compare width: holds the timers, a register value and twice the press time
    localparam int CW = (TIMER_WIDTH > CFG_W + 1) ? TIMER_WIDTH : CFG_W + 1;
    localparam logic [TIMER_WIDTH-1:0] TMAX     = {TIMER_WIDTH{1'b1}};
    localparam logic [CW-1:0]          LEVEL_CAP = CW'({LEVEL_OUT_W{1'b1}});

    logic                   r_active;
    t_btn_state             r_state;
    logic [TIMER_WIDTH-1:0] r_db_cnt;
    logic [TIMER_WIDTH-1:0] r_lv_cnt;

    logic                   n_active;
    t_btn_state             n_state;
    logic [TIMER_WIDTH-1:0] n_db_cnt;
    logic [TIMER_WIDTH-1:0] n_lv_cnt;

    logic                   edge_clr;
    logic [TIMER_WIDTH-1:0] db_base;
    logic [TIMER_WIDTH-1:0] lv_base;
    logic [TIMER_WIDTH-1:0] db_adv;
    logic [TIMER_WIDTH-1:0] lv_adv;
    logic                   differ;
    logic [CFG_W-1:0]       need;
    logic                   level_take;
    logic [CW-1:0]          lv_ext;
    logic                   hit_start;
    logic                   hit_short;
    logic                   hit_long;

    // Timers: edge restart while released, then saturating advance
    always_comb begin
        edge_clr = (r_state == ST_RELEASED) && i_press_edge;
        db_base  = edge_clr ? '0 : r_db_cnt;
        lv_base  = edge_clr ? '0 : r_lv_cnt;
        db_adv   = (db_base == TMAX) ? db_base : db_base + TIMER_WIDTH'(1);
        lv_adv   = (lv_base == TMAX) ? lv_base : lv_base + TIMER_WIDTH'(1);
    end

    // Debounce: a differing level is taken once it has lasted long enough
    always_comb begin
        differ     = i_raw_active != r_active;
        need       = i_raw_active ? i_cfg.press_db : i_cfg.release_db;
        level_take = differ && (CW'(db_adv) >= CW'(need));
        n_active   = level_take ? i_raw_active : r_active;
        n_db_cnt   = (level_take || !differ) ? '0 : db_adv;
        n_lv_cnt   = level_take ? '0 : lv_adv;
        lv_ext     = CW'(n_lv_cnt);
    end

    // Next state from the level time; of the enabled holds, long wins, then short, then start
    always_comb begin
        hit_long  = (i_cfg.hold_long  != NO_HOLD) && (lv_ext >= CW'(i_cfg.hold_long));
        hit_short = (i_cfg.hold_short != NO_HOLD) && (lv_ext >= CW'(i_cfg.hold_short));
        hit_start = (i_cfg.hold_start != NO_HOLD) && (lv_ext >= CW'(i_cfg.hold_start));
        if (!n_active) begin
            n_state = ST_RELEASED;
        end else if (hit_long) begin
            n_state = ST_HOLD_LONG;
        end else if (hit_short) begin
            n_state = ST_HOLD_SHORT;
        end else if (hit_start) begin
            n_state = ST_HOLD_START;
        end else begin
            n_state = ST_PRESSED;
        end
    end

    // Result item for this tick
    always_comb begin
        o_result.button_state   = n_state;
        o_result.previous_state = r_state;
        o_result.state_changed  = n_state != r_state;
        o_result.is_idle        = (n_state == ST_RELEASED)
                                  && (lv_ext > CW'({i_cfg.press_db, 1'b0}));
        o_result.level_ticks    = (lv_ext > LEVEL_CAP) ? {LEVEL_OUT_W{1'b1}}
                                                       : lv_ext[LEVEL_OUT_W-1:0];
    end

    // State registers advance once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_state  <= ST_RELEASED;
            r_db_cnt <= '0;
            r_lv_cnt <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_state  <= n_state;
            r_db_cnt <= n_db_cnt;
            r_lv_cnt <= n_lv_cnt;
        end
    end

endmodule

[hdl/bdhc_checker.sv]
// Port-level checker for the button debounce core, bound to the top level.
// Depends on bdhc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "button_debounce_hold_classifier_core_defines.svh"

module bdhc_checker
    import bdhc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [2:0]             o_button_state,
    input logic [2:0]             o_previous_state,
    input logic                   o_is_idle,
    input logic [LEVEL_OUT_W-1:0] o_level_ticks
);

    logic       out_take;
    logic [2:0] r_last_state;

    assign out_take = o_out_valid && i_out_ready;

    // State reported by the last delivered item; released after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_state <= ST_RELEASED;
        end else if (out_take) begin
            r_last_state <= o_button_state;
        end
    end

    // A stalled result holds
    `BDHC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_button_state) && $stable(o_level_ticks), "result changed while stalled")

    // Each item continues from the state the previous item reported
    `BDHC_ASSERT(a_prev_chain, i_clk, i_rst_n, o_out_valid |-> o_previous_state == r_last_state, "previous state breaks the chain")

    // Idle only while released and with some level time
    `BDHC_ASSERT(a_idle_rel, i_clk, i_rst_n, o_out_valid && o_is_idle |-> o_button_state == ST_RELEASED && o_level_ticks != '0, "idle while not released")

    // No result right after reset
    `BDHC_ASSERT_ALWAYS(a_rst_empty, i_clk, $past(!i_rst_n) |-> !o_out_valid, "result valid after reset")

endmodule

bind button_debounce_hold_classifier_core bdhc_checker u_bdhc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_button_state   (o_button_state),
    .o_previous_state (o_previous_state),
    .o_is_idle        (o_is_idle),
    .o_level_ticks    (o_level_ticks)
);

[tb/tb_button_debounce_hold_classifier_core.sv]
// Self-checking bench for the button debounce and hold classifier core.
// Depends on bdhc_pkg and button_debounce_hold_classifier_core; each result item
// is checked against a queue filled by a built-in tick predictor or typed rows.
`timescale 1ns / 1ps

module tb_button_debounce_hold_classifier_core;
    import bdhc_pkg::*;

    localparam int RESULT_LATENCY = 2;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RAND_PHASES    = 7;
    localparam int PHASE_TICKS    = 72;
    localparam int DIR_ROWS       = 33;

    // Indexes above the last register; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam logic [TIMER_WIDTH_DEF-1:0] TIMER_TOP = '1;

    typedef enum bit { ROW_TICK, ROW_CFG } t_row_kind;

    // One row of the directed table: a register write or a tick
    typedef struct {
        t_row_kind          kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]   data;
        bit                 raw;
        bit                 pedge;
        bit                 typed;
        t_result            want;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_raw_active;
    logic                   i_press_edge;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [2:0]             o_button_state;
    logic [2:0]             o_previous_state;
    logic                   o_state_changed;
    logic                   o_is_idle;
    logic [LEVEL_OUT_W-1:0] o_level_ticks;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_wdata;

    button_debounce_hold_classifier_core #(
        .TIMER_WIDTH (TIMER_WIDTH_DEF)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_raw_active     (i_raw_active),
        .i_press_edge     (i_press_edge),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_button_state   (o_button_state),
        .o_previous_state (o_previous_state),
        .o_state_changed  (o_state_changed),
        .o_is_idle        (o_is_idle),
        .o_level_ticks    (o_level_ticks),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // Predictor state and configuration copy
    t_cfg                         cfg_model;
    logic                         db_level;
    t_btn_state                   btn_state;
    logic [TIMER_WIDTH_DEF-1:0]   bounce_cnt;
    logic [TIMER_WIDTH_DEF-1:0]   level_cnt;

    t_result pending_results [$];
    int      fail_count    = 0;
    int      ticks_sent    = 0;
    int      results_seen  = 0;
    int      reg_writes    = 0;
    int      cycle_count   = 0;
    int      in_idle_pct   = 0;
    int      out_idle_pct  = 0;
    int      stall_left    = 0;

    // Directed table: reset defaults, zero debounce, all hold steps,
    // disabled steps, edge while pressed, spare register indexes
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b0, 1'b1,
          '{ST_RELEASED, ST_RELEASED, 1'b0, 1'b0, 16'd1}},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b1, 1'b1,
          '{ST_PRESSED, ST_RELEASED, 1'b1, 1'b0, 16'd0}},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_CFG,  CFG_PRESS_DB,   16'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_RELEASE_DB, 16'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_HOLD_START, 16'd2, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_HOLD_SHORT, 16'd4, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_HOLD_LONG,  16'd6, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_SPARE_FIRST, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_SPARE_LAST,  16'hAAAA, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b1, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_CFG,  CFG_HOLD_START, 16'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_HOLD_SHORT, 16'd0, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  CFG_HOLD_LONG,  16'd3, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_TICK, CFG_PRESS_DB, '0, 1'b0, 1'b0, 1'b0, '0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit hold_reached(logic [TIMER_WIDTH_DEF-1:0] t,
                                        logic [CFG_W-1:0] thr);
        return (thr != NO_HOLD) && (t >= thr);
    endfunction

    // Advance the debouncer by one tick and classify the hold time
    function automatic t_result classify_tick(logic raw, logic pedge);
        t_result          r;
        t_btn_state       prev;
        t_btn_state       nxt;
        logic [CFG_W-1:0] need;
        logic [CFG_W:0]   idle_thr;
        prev = btn_state;
        nxt  = ST_RELEASED;
        // an edge only restarts the timers while released
        if (btn_state == ST_RELEASED && pedge) begin
            bounce_cnt = '0;
            level_cnt  = '0;
        end
        if (bounce_cnt != TIMER_TOP) bounce_cnt++;
        if (level_cnt != TIMER_TOP) level_cnt++;
        if (raw != db_level) begin
            need = raw ? cfg_model.press_db : cfg_model.release_db;
            if (bounce_cnt >= need) begin
                db_level   = raw;
                level_cnt  = '0;
                bounce_cnt = '0;
            end
        end else begin
            bounce_cnt = '0;
        end
        if (db_level) begin
            if (hold_reached(level_cnt, cfg_model.hold_long))
                nxt = ST_HOLD_LONG;
            else if (hold_reached(level_cnt, cfg_model.hold_short))
                nxt = ST_HOLD_SHORT;
            else if (hold_reached(level_cnt, cfg_model.hold_start))
                nxt = ST_HOLD_START;
            else
                nxt = ST_PRESSED;
        end
        btn_state = nxt;
        // twice the press debounce needs one extra bit
        idle_thr           = {cfg_model.press_db, 1'b0};
        r.button_state     = nxt;
        r.previous_state   = prev;
        r.state_changed    = (nxt != prev);
        r.is_idle          = (nxt == ST_RELEASED) && ({1'b0, level_cnt} > idle_thr);
        r.level_ticks      = level_cnt;
        return r;
    endfunction

    // Offer one tick item; entered right after an accepting edge, a register write or at start
    task automatic send_tick(bit raw, bit pedge, bit typed, t_result want);
        int      gap;
        t_result got;
        gap = ($urandom_range(0, 99) < in_idle_pct) ? $urandom_range(1, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_raw_active = raw;
        i_press_edge = pedge;
        do @(posedge i_clk); while (!o_in_ready);
        got = classify_tick(raw, pedge);
        pending_results.push_back(typed ? want : got);
        ticks_sent++;
    endtask

    // Register write, only once every expected item has come out
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (RESULT_LATENCY) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_PRESS_DB:   cfg_model.press_db   = val;
            CFG_RELEASE_DB: cfg_model.release_db = val;
            CFG_HOLD_START: cfg_model.hold_start = val;
            CFG_HOLD_SHORT: cfg_model.hold_short = val;
            CFG_HOLD_LONG:  cfg_model.hold_long  = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Mostly short debounce times, now and then zero or a full-range value
    function automatic logic [CFG_W-1:0] pick_debounce();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r <= 6) return CFG_W'($urandom_range(1, 4));
        if (r <= 8) return CFG_W'($urandom_range(5, 12));
        return CFG_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_hold();
        return ($urandom_range(0, 9) < 2) ? NO_HOLD : CFG_W'($urandom_range(1, 30));
    endfunction

    function automatic void report_field(string name, logic [15:0] exp_v,
                                         logic [15:0] act_v);
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, act_v);
        fail_count++;
    endfunction

    // Receiver stalls in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready = 1'b0;
            stall_left--;
        end else begin
            i_out_ready = 1'b1;
            if ($urandom_range(0, 99) < out_idle_pct) stall_left = $urandom_range(1, 8);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item with nothing expected, state %0d level %0d",
                         $time, o_button_state, o_level_ticks);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_button_state !== want.button_state)
                    report_field("button_state", want.button_state, o_button_state);
                if (o_previous_state !== want.previous_state)
                    report_field("previous_state", want.previous_state, o_previous_state);
                if (o_state_changed !== want.state_changed)
                    report_field("state_changed", want.state_changed, o_state_changed);
                if (o_is_idle !== want.is_idle)
                    report_field("is_idle", want.is_idle, o_is_idle);
                if (o_level_ticks !== want.level_ticks)
                    report_field("level_ticks", want.level_ticks, o_level_ticks);
                results_seen++;
            end
        end
    end

    // Stimulus
    initial begin
        int n;
        int len;
        int k;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_raw_active = 1'b0;
        i_press_edge = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_wdata  = '0;

        cfg_model.press_db   = PRESS_DB_RST;
        cfg_model.release_db = RELEASE_DB_RST;
        cfg_model.hold_start = HOLD_RST;
        cfg_model.hold_short = HOLD_RST;
        cfg_model.hold_long  = HOLD_RST;
        db_level   = 1'b0;
        btn_state  = ST_RELEASED;
        bounce_cnt = '0;
        level_cnt  = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        in_idle_pct  = 20;
        out_idle_pct = 10;
        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].kind == ROW_CFG)
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            else
                send_tick(dir_rows[k].raw, dir_rows[k].pedge, dir_rows[k].typed,
                          dir_rows[k].want);
        end

        // random phases of press/release sequences with bounce, plus noise
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == RAND_PHASES - 1) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = 20 * $urandom_range(0, 2);
                out_idle_pct = 10 * $urandom_range(0, 2);
            end
            write_reg(CFG_PRESS_DB, pick_debounce());
            write_reg(CFG_RELEASE_DB, pick_debounce());
            write_reg(CFG_HOLD_START, pick_hold());
            write_reg(CFG_HOLD_SHORT, pick_hold());
            write_reg(CFG_HOLD_LONG, pick_hold());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                          CFG_W'($urandom));
            n = 0;
            while (n < PHASE_TICKS) begin
                if ($urandom_range(0, 99) < 85) begin
                    len = $urandom_range(1, 40);
                    for (k = 0; k < len; k++)
                        send_tick($urandom_range(0, 99) >= 8,
                                  (k == 0) ? ($urandom_range(0, 99) < 80)
                                           : ($urandom_range(0, 99) < 10),
                                  1'b0, '0);
                    n += len;
                    len = $urandom_range(1, 20);
                    for (k = 0; k < len; k++)
                        send_tick($urandom_range(0, 99) < 8, $urandom_range(0, 99) < 5,
                                  1'b0, '0);
                    n += len;
                end else begin
                    len = $urandom_range(1, 6);
                    for (k = 0; k < len; k++)
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'b0, '0);
                    n += len;
                end
            end
        end

        // drain and let the pipeline settle
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 4) @(posedge i_clk);

        $display("run: %0d ticks, %0d results checked, %0d register writes, %0d mismatches",
                 ticks_sent, results_seen, reg_writes, fail_count);
        $display("covered reset defaults, zero and wide debounce, every hold step, stalls");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
